// ===== src/assert_macros.svh =====
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// expr must hold at every clock edge out of reset
`define ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("%m: assertion failed");

// cons must hold in the same cycle as ante
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: assertion failed");

`else

`define ASSERT_ALWAYS(label, clk, rst_n, expr)
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== src/ffa_pkg.sv =====
`default_nettype none

package ffa_pkg;

    localparam int POOL_BYTES_DEF   = 65536;
    localparam int HEADER_BYTES_DEF = 12;
    localparam int WORD_BYTES_DEF   = 8;
    localparam int MAX_CHUNKS_DEF   = 4096;

    // header + length before padding
    localparam int FULL_W = 17;
    localparam int PAD_W  = 3;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_OOM       = 2'd1,
        ST_BOUNDS    = 2'd2,
        ST_UNMANAGED = 2'd3
    } status_t;

    typedef struct packed {
        logic             busy;
        logic [PAD_W-1:0] pad;
        logic [15:0]      size;
        logic [15:0]      start;
    } chunk_entry_t;

endpackage

`default_nettype wire

// ===== src/ffa_pad.sv =====
`default_nettype none

// Padding of value up to a multiple of WORD_BYTES, from the remainder by
// WORD_BYTES through a reciprocal multiply. pad is valid once busy is low.
module ffa_pad #(
    parameter int WORD_BYTES = ffa_pkg::WORD_BYTES_DEF
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    input  wire logic [ffa_pkg::FULL_W-1:0] value,
    output logic                            busy,
    output logic [ffa_pkg::PAD_W-1:0]       pad
);
    import ffa_pkg::*;

    // floor(v * ceil(2^SHIFT / W) / 2^SHIFT) equals floor(v / W) for every
    // v below 2^FULL_W while W <= 2^PAD_W
    localparam int SHIFT   = FULL_W + PAD_W;
    localparam int RECIP_W = SHIFT + 1;
    localparam int PROD_W  = FULL_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP_L =
        RECIP_W'(((1 << SHIFT) + WORD_BYTES - 1) / WORD_BYTES);
    localparam logic [FULL_W-1:0]  WORD_F  = FULL_W'(WORD_BYTES);
    localparam logic [PAD_W:0]     WORD_L  = (PAD_W + 1)'(WORD_BYTES);
    localparam logic [1:0]         STEPS_L = 2'd2;

    logic [FULL_W-1:0] val_reg;
    logic [FULL_W-1:0] quo_reg;
    logic [PAD_W-1:0]  rem_reg;
    logic [1:0]        cnt_reg;
    logic [PROD_W-1:0] prod;
    logic [FULL_W-1:0] back;
    logic [FULL_W-1:0] rem_full;

    assign prod     = {{(PROD_W - FULL_W){1'b0}}, val_reg} *
                      {{(PROD_W - RECIP_W){1'b0}}, RECIP_L};
    assign back     = quo_reg * WORD_F;
    assign rem_full = val_reg - back;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else if (start)
            cnt_reg <= STEPS_L;
        else if (cnt_reg != '0)
            cnt_reg <= cnt_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (start)
            val_reg <= value;
        if (cnt_reg == STEPS_L)
            quo_reg <= prod[SHIFT +: FULL_W];
        if (cnt_reg == 2'd1)
            rem_reg <= rem_full[PAD_W-1:0];
    end

    assign busy = (cnt_reg != '0);

    always_comb
    begin
        logic [PAD_W:0] diff;
        diff = WORD_L - {1'b0, rem_reg};
        if (rem_reg == '0)
            pad = '0;
        else
            pad = diff[PAD_W-1:0];
    end

endmodule

`default_nettype wire

// ===== src/first_fit_chunk_allocator.sv =====
// First-fit chunk allocator over a fixed byte pool, one request at a time.
// The chunk descriptor table sits in one synchronous RAM and a request walks
// it one entry per cycle. A request's result is registered when its walk
// stops, at the first entry that matches or once all chunks of the table
// have been checked without a hit; S_DONE then moves it to the output
// register, and the next request is taken once the block is back in S_IDLE.
// An append also needs the word padding, which the remainder unit works out
// from acceptance on; it hides behind any walk of one entry or more, so only
// an append to an empty table waits for it before its result is registered.
// A free to an empty table ends its walk without reading an entry, and a free
// whose address is out of bounds skips the walk. A finished request waits
// while the output register holds a stalled beat; the block goes idle as soon
// as the result enters the output register, even if that beat stalls in turn.
// The table needs no clearing pass after reset.
`default_nettype none
`include "assert_macros.svh"

module first_fit_chunk_allocator #(
    parameter int POOL_BYTES   = ffa_pkg::POOL_BYTES_DEF,
    parameter int HEADER_BYTES = ffa_pkg::HEADER_BYTES_DEF,
    parameter int WORD_BYTES   = ffa_pkg::WORD_BYTES_DEF,
    parameter int MAX_CHUNKS   = ffa_pkg::MAX_CHUNKS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic        cmd,
    input  wire logic [15:0] length,
    input  wire logic [15:0] address,

    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [1:0]       status,
    output logic [15:0]      data_offset,
    output logic [15:0]      granted_size,
    output logic             reused,
    output logic [15:0]      pool_used,
    output logic [31:0]      allocated_total,
    output logic [31:0]      freed_total
);
    import ffa_pkg::*;

    localparam int IDX_W = $clog2(MAX_CHUNKS);
    localparam int CNT_W = $clog2(MAX_CHUNKS + 1);

    localparam logic [FULL_W-1:0] POOL_L   = FULL_W'(POOL_BYTES);
    localparam logic [FULL_W-1:0] HDR_L    = FULL_W'(HEADER_BYTES);
    localparam logic [FULL_W-1:0] BOUND_HI = FULL_W'(POOL_BYTES - HEADER_BYTES);
    localparam logic [CNT_W-1:0]  CNT_MAX  = CNT_W'(MAX_CHUNKS);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } state_t;

    state_t state_reg;

    logic        cmd_reg;
    logic [15:0] len_reg;
    logic [15:0] addr_reg;

    logic [CNT_W-1:0] count_reg;
    logic [15:0]      pos_reg;
    logic [31:0]      asum_reg;
    logic [31:0]      fsum_reg;

    logic [CNT_W-1:0] idx_reg;
    logic [IDX_W-1:0] chk_reg;
    logic             rd_vld_reg;
    chunk_entry_t     rdata_reg;

    status_t     res_status_reg;
    logic [15:0] res_offset_reg;
    logic [15:0] res_size_reg;
    logic        res_reused_reg;

    logic        out_valid_reg;
    status_t     status_reg;
    logic [15:0] offset_reg;
    logic [15:0] size_reg;
    logic        reused_reg;
    logic [15:0] used_reg;
    logic [31:0] atot_reg;
    logic [31:0] ftot_reg;

    chunk_entry_t table_mem [MAX_CHUNKS];

    logic              accept;
    logic              addr_oob;
    logic [FULL_W-1:0] start_hdr;
    logic              alloc_fit;
    logic              free_match;
    logic              scan_hit;
    logic              scan_end;
    logic              rd_en;
    logic [FULL_W:0]   full_len;
    logic [FULL_W:0]   need_end;
    logic              oom;
    logic              append_go;
    logic              mem_we;
    logic [IDX_W-1:0]  mem_waddr;
    chunk_entry_t      mem_wdata;

    logic              pad_start;
    logic [FULL_W-1:0] pad_val;
    logic              pad_busy;
    logic [PAD_W-1:0]  pad;

    assign in_stall = (state_reg != S_IDLE);
    assign accept   = in_valid && (state_reg == S_IDLE);

    assign addr_oob = ({1'b0, address} < HDR_L) || ({1'b0, address} > BOUND_HI);

    // padding is worked out while the table walk runs
    assign pad_start = accept && (cmd == CMD_ALLOC);
    assign pad_val   = {1'b0, length} + HDR_L;

    ffa_pad #(
        .WORD_BYTES (WORD_BYTES)
    ) u_pad (
        .clk   (clk),
        .rst_n (rst_n),
        .start (pad_start),
        .value (pad_val),
        .busy  (pad_busy),
        .pad   (pad)
    );

    assign start_hdr  = {1'b0, rdata_reg.start} + HDR_L;
    assign alloc_fit  = !rdata_reg.busy && (rdata_reg.size >= len_reg);
    assign free_match = (start_hdr == {1'b0, addr_reg});

    assign scan_hit = (state_reg == S_SCAN) && rd_vld_reg &&
                      ((cmd_reg == CMD_ALLOC) ? alloc_fit : free_match);
    // all entries read and checked without a hit
    assign scan_end = (state_reg == S_SCAN) && !rd_vld_reg && (idx_reg == count_reg);
    assign rd_en    = (state_reg == S_SCAN) && (idx_reg != count_reg) && !scan_hit;

    assign full_len  = {2'b00, len_reg} + {1'b0, HDR_L} + {{(FULL_W + 1 - PAD_W){1'b0}}, pad};
    assign need_end  = {{(FULL_W - 15){1'b0}}, pos_reg} + full_len;
    assign oom       = (count_reg == CNT_MAX) || (need_end >= {1'b0, POOL_L});
    assign append_go = scan_end && (cmd_reg == CMD_ALLOC) && !pad_busy && !oom;

    always_comb
    begin
        mem_we    = scan_hit || append_go;
        mem_waddr = scan_hit ? chk_reg : count_reg[IDX_W-1:0];
        if (scan_hit)
        begin
            mem_wdata      = rdata_reg;
            mem_wdata.busy = (cmd_reg == CMD_ALLOC);
        end
        else
        begin
            mem_wdata.busy  = 1'b1;
            mem_wdata.pad   = pad;
            mem_wdata.size  = len_reg;
            mem_wdata.start = pos_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
            rdata_reg <= table_mem[idx_reg[IDX_W-1:0]];
        if (mem_we)
            table_mem[mem_waddr] <= mem_wdata;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg  <= cmd;
            len_reg  <= length;
            addr_reg <= address;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            pos_reg        <= '0;
            asum_reg       <= '0;
            fsum_reg       <= '0;
            idx_reg        <= '0;
            chk_reg        <= '0;
            rd_vld_reg     <= 1'b0;
            res_status_reg <= ST_OK;
            res_offset_reg <= '0;
            res_size_reg   <= '0;
            res_reused_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            status_reg     <= ST_OK;
            offset_reg     <= '0;
            size_reg       <= '0;
            reused_reg     <= 1'b0;
            used_reg       <= '0;
            atot_reg       <= '0;
            ftot_reg       <= '0;
        end
        else
        begin
            // S_DONE drives out_valid_reg itself
            if (out_valid_reg && !out_stall && state_reg != S_DONE)
                out_valid_reg <= 1'b0;

            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        idx_reg    <= '0;
                        rd_vld_reg <= 1'b0;
                        if (cmd == CMD_FREE && addr_oob)
                        begin
                            res_status_reg <= ST_BOUNDS;
                            res_offset_reg <= '0;
                            res_size_reg   <= '0;
                            res_reused_reg <= 1'b0;
                            state_reg      <= S_DONE;
                        end
                        else
                            state_reg <= S_SCAN;
                    end
                end

                S_SCAN:
                begin
                    if (rd_en)
                        idx_reg <= idx_reg + 1'b1;
                    chk_reg    <= idx_reg[IDX_W-1:0];
                    rd_vld_reg <= rd_en;

                    if (scan_hit)
                    begin
                        res_status_reg <= ST_OK;
                        res_size_reg   <= rdata_reg.size;
                        if (cmd_reg == CMD_ALLOC)
                        begin
                            asum_reg       <= asum_reg + {16'b0, rdata_reg.size};
                            res_offset_reg <= start_hdr[15:0];
                            res_reused_reg <= 1'b1;
                        end
                        else
                        begin
                            fsum_reg       <= fsum_reg + {16'b0, rdata_reg.size};
                            res_offset_reg <= '0;
                            res_reused_reg <= 1'b0;
                        end
                        state_reg <= S_DONE;
                    end
                    else if (scan_end)
                    begin
                        res_reused_reg <= 1'b0;
                        if (cmd_reg == CMD_FREE)
                        begin
                            res_status_reg <= ST_UNMANAGED;
                            res_offset_reg <= '0;
                            res_size_reg   <= '0;
                            state_reg      <= S_DONE;
                        end
                        else if (!pad_busy)
                        begin
                            if (oom)
                            begin
                                res_status_reg <= ST_OOM;
                                res_offset_reg <= '0;
                                res_size_reg   <= '0;
                            end
                            else
                            begin
                                count_reg      <= count_reg + 1'b1;
                                pos_reg        <= need_end[15:0];
                                asum_reg       <= asum_reg + {16'b0, len_reg};
                                res_status_reg <= ST_OK;
                                res_offset_reg <= pos_reg + HDR_L[15:0];
                                res_size_reg   <= len_reg;
                            end
                            state_reg <= S_DONE;
                        end
                    end
                end

                S_DONE:
                begin
                    rd_vld_reg <= 1'b0;
                    if (!out_valid_reg || !out_stall)
                    begin
                        out_valid_reg <= 1'b1;
                        status_reg    <= res_status_reg;
                        offset_reg    <= res_offset_reg;
                        size_reg      <= res_size_reg;
                        reused_reg    <= res_reused_reg;
                        used_reg      <= pos_reg;
                        atot_reg      <= asum_reg;
                        ftot_reg      <= fsum_reg;
                        state_reg     <= S_IDLE;
                    end
                end

                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    assign out_valid       = out_valid_reg;
    assign status          = status_reg;
    assign data_offset     = offset_reg;
    assign granted_size    = size_reg;
    assign reused          = reused_reg;
    assign pool_used       = used_reg;
    assign allocated_total = atot_reg;
    assign freed_total     = ftot_reg;

    `ASSERT_ALWAYS(a_count_max, clk, rst_n, count_reg <= CNT_MAX)
    `ASSERT_ALWAYS(a_pos_in_pool, clk, rst_n, {1'b0, pos_reg} < POOL_L)
    `ASSERT_IMPLIES(a_read_in_scan, clk, rst_n, rd_vld_reg, state_reg == S_SCAN)
    `ASSERT_IMPLIES(a_count_step, clk, rst_n, count_reg != $past(count_reg),
        count_reg == $past(count_reg) + 1'b1 && $past(state_reg) == S_SCAN)

endmodule

`default_nettype wire
